// File: sv/lruc_pkg.sv
// Shared constants and controller/datapath interface types for the LRU cache.
package lruc_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int KEY_W         = 64;
    localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANK_W        = IDX_W;
    localparam int CNT_W         = $clog2(DEPTH + 1);

    // Configuration register file
    localparam int CAP_W         = 5;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Command kinds carried on the input tuser bit
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic load;     // capture the accepted item and its match vector
        logic update;   // apply recency/store update and load the result
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy; // result register holds an item not yet taken
    } dp_status_t;

endpackage

// File: sv/lruc_ctrl.sv
// Controller state machine: sequences accept and update for each item.
module lruc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lruc_pkg::dp_status_t status,
    output lruc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Accept in idle, update once the result register is free
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!status.out_busy) begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/lruc_datapath.sv
// Datapath: entry store, parallel key compare, recency ranks and result register.
module lruc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lruc_pkg::ctrl_cmd_t                 cmd,
    output lruc_pkg::dp_status_t                status,
    input  logic [lruc_pkg::CAP_W-1:0]          capacity,
    input  logic                                in_cmd,
    input  logic signed [lruc_pkg::KEY_W-1:0]   in_key,
    input  logic [lruc_pkg::PAYLOAD_WIDTH-1:0]  in_payload,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                out_hit,
    output logic [lruc_pkg::PAYLOAD_WIDTH-1:0]  out_data
);

    localparam int D  = lruc_pkg::DEPTH;
    localparam int RW = lruc_pkg::RANK_W;
    localparam int CW = lruc_pkg::CNT_W;
    localparam int PW = lruc_pkg::PAYLOAD_WIDTH;

    // Entry store
    logic signed [lruc_pkg::KEY_W-1:0] keys_reg [D];
    logic [PW-1:0]                     data_reg [D];
    logic [D-1:0]                      valid_reg, valid_next;
    logic [RW-1:0]                     rank_reg  [D];
    logic [RW-1:0]                     rank_next [D];
    logic [CW-1:0]                     occ_reg, occ_next;

    // Captured item
    logic                              cmd_reg;
    logic signed [lruc_pkg::KEY_W-1:0] key_reg;
    logic [PW-1:0]                     pay_reg;
    logic [D-1:0]                      match_reg, match_next;

    // Result register
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [PW-1:0] out_data_reg;

    logic          hit;
    logic [RW-1:0] hit_rank;
    logic [PW-1:0] hit_data;
    logic [CW-1:0] eff_cap;
    logic [CW-1:0] occ_m1;
    logic          evict;
    logic [D-1:0]  victim;
    logic [D-1:0]  avail;
    logic [D-1:0]  free_slot;

    // Compare the incoming key against every valid entry
    always_comb begin
        for (int i = 0; i < D; i++) begin
            match_next[i] = valid_reg[i] && (keys_reg[i] == in_key);
        end
    end

    // Select rank and payload of the matching entry
    always_comb begin
        hit_rank = '0;
        hit_data = '0;
        for (int i = 0; i < D; i++) begin
            if (match_reg[i]) begin
                hit_rank = hit_rank | rank_reg[i];
                hit_data = hit_data | data_reg[i];
            end
        end
    end

    assign hit = |match_reg;

    // Clamp capacity to 1..DEPTH
    always_comb begin
        if (capacity == '0) begin
            eff_cap = CW'(1);
        end else if (int'(capacity) > D) begin
            eff_cap = CW'(D);
        end else begin
            eff_cap = CW'(capacity);
        end
    end

    // Oldest valid entry holds rank occupancy-1
    assign occ_m1 = occ_reg - CW'(1);
    assign evict  = !hit && (cmd_reg == lruc_pkg::CMD_INSERT) && (occ_reg >= eff_cap);

    always_comb begin
        for (int i = 0; i < D; i++) begin
            victim[i] = evict && valid_reg[i] && (CW'(rank_reg[i]) == occ_m1);
        end
    end

    // Lowest free slot after eviction
    assign avail     = ~valid_reg | victim;
    assign free_slot = avail & (~avail + D'(1));

    // Next ranks, valid bits and occupancy
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < D; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.update) begin
            if (hit) begin
                for (int i = 0; i < D; i++) begin
                    if (match_reg[i]) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
            end else if (cmd_reg == lruc_pkg::CMD_INSERT) begin
                for (int i = 0; i < D; i++) begin
                    if (free_slot[i]) begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end else if (victim[i]) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                if (!evict) begin
                    occ_next = occ_reg + CW'(1);
                end
            end
        end
    end

    // Control state: valid bits, ranks, occupancy, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < D; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < D; i++) begin
                rank_reg[i] <= rank_next[i];
            end
            if (cmd.update) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: captured item, stored entries, result fields
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_cmd;
            key_reg   <= in_key;
            pay_reg   <= in_payload;
            match_reg <= match_next;
        end
        if (cmd.update) begin
            out_hit_reg  <= hit;
            out_data_reg <= (hit && (cmd_reg == lruc_pkg::CMD_LOOKUP)) ? hit_data : '0;
            if (!hit && (cmd_reg == lruc_pkg::CMD_INSERT)) begin
                for (int i = 0; i < D; i++) begin
                    if (free_slot[i]) begin
                        keys_reg[i] <= key_reg;
                        data_reg[i] <= pay_reg;
                    end
                end
            end
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_data        = out_data_reg;

    // Occupancy tracks the number of valid entries
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    // A new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> !(out_valid_reg && !m_tready))
        else $error("result overwritten before taken");

    // A miss always reports zero data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_hit_reg) |-> (out_data_reg == '0))
        else $error("miss result carries nonzero data");

    // An insert of a new key always finds exactly one free slot, after any eviction
    a_insert_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && !hit && (cmd_reg == lruc_pkg::CMD_INSERT)) |-> $onehot(free_slot))
        else $error("insert found no free slot");

endmodule

// File: sv/lru_cache_by_key.sv
// Top level of the LRU cache by key: stream ports, APB capacity register, core.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tdata = key[63:0], payload[95:64]; tuser = cmd
//  m_        out  m_tvalid/m_tready  tdata = data[31:0]; tuser = hit
//  apb       in   psel/penable       capacity at byte address 0
//
//  Each item is accepted and its key compared against all 16 entries in the idle
//  state; the update state then updates ranks and the store and loads the result register.
//  The next item is accepted while the result waits; a stalled result holds the
//  update cycle of the following item. Synchronous active-low reset empties the
//  cache and sets capacity to 16; no clearing pass is needed.
module lru_cache_by_key (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input item stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [95:0]                       s_tdata,  // key[63:0], payload[95:64]
    input  logic                              s_tuser,  // cmd[0]
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // data[31:0]
    output logic                              m_tuser,  // hit[0]
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lruc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lruc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lruc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    lruc_pkg::ctrl_cmd_t         cmd;
    lruc_pkg::dp_status_t        status;
    logic [lruc_pkg::CAP_W-1:0]  capacity_reg, capacity_next;
    logic                        apb_wr;

    // Capacity register write
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb begin
        capacity_next = capacity_reg;
        if (apb_wr && (paddr[2] == lruc_pkg::REG_CAPACITY)) begin
            capacity_next = pwdata[lruc_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lruc_pkg::CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        if (paddr[2] == lruc_pkg::REG_CAPACITY) begin
            prdata = {{(lruc_pkg::APB_DATA_W - lruc_pkg::CAP_W){1'b0}}, capacity_reg};
        end
    end

    lruc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lruc_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .capacity   (capacity_reg),
        .in_cmd     (s_tuser),
        .in_key     (s_tdata[63:0]),
        .in_payload (s_tdata[95:64]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_hit    (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

// File: tb/lru_cache_by_key_tb.sv
// Testbench for the LRU cache by key: directed and random stream traffic checked against a shadow cache.
module lru_cache_by_key_tb;

    localparam logic [lruc_pkg::APB_ADDR_W-1:0] CAP_ADDR   =
        lruc_pkg::APB_ADDR_W'(4 * lruc_pkg::REG_CAPACITY);
    localparam logic [lruc_pkg::APB_ADDR_W-1:0] SPARE_ADDR =
        CAP_ADDR + lruc_pkg::APB_ADDR_W'(4);
    localparam logic [63:0] KEY_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          POOL_SIZE     = 24;
    localparam int          PHASE_ITEMS   = 68;

    // Shadow copy of the cache: predicts hit and data for each accepted request
    class lru_shadow;
        typedef struct {
            logic        hit;
            logic [31:0] data;
        } reply_t;

        logic [63:0]  keys[lruc_pkg::DEPTH];
        logic [31:0]  vals[lruc_pkg::DEPTH];
        bit           used[lruc_pkg::DEPTH];
        int unsigned  rank[lruc_pkg::DEPTH];
        int unsigned  occupancy;
        logic [4:0]   capacity;
        reply_t       due_replies[$];
        int           errors;

        function new();
            for (int i = 0; i < lruc_pkg::DEPTH; i++) begin
                keys[i] = '0;
                vals[i] = '0;
                used[i] = 1'b0;
                rank[i] = 0;
            end
            occupancy = 0;
            capacity  = lruc_pkg::CAP_RESET;
            errors    = 0;
        endfunction

        function void set_capacity(logic [31:0] value);
            capacity = value[4:0];
        endfunction

        function void accept_request(logic cmd, logic [63:0] key, logic [31:0] payload);
            int          slot;
            int          victim;
            int unsigned limit;
            int unsigned oldest;
            int unsigned r;
            reply_t      reply;
            slot = -1;
            for (int i = 0; i < lruc_pkg::DEPTH; i++)
                if (slot < 0 && used[i] && keys[i] == key)
                    slot = i;
            reply.hit  = 1'b0;
            reply.data = '0;
            // Hit: promote to most recent, return payload on lookup only
            if (slot >= 0) begin
                r = rank[slot];
                for (int i = 0; i < lruc_pkg::DEPTH; i++)
                    if (used[i] && rank[i] < r)
                        rank[i]++;
                rank[slot] = 0;
                reply.hit  = 1'b1;
                if (cmd == lruc_pkg::CMD_LOOKUP)
                    reply.data = vals[slot];
                due_replies = {due_replies, reply};
                return;
            end
            due_replies = {due_replies, reply};
            if (cmd == lruc_pkg::CMD_LOOKUP)
                return;
            // Miss on insert: drop the least recent entry when full
            limit = (capacity == 0) ? 1 :
                    (capacity > lruc_pkg::DEPTH) ? lruc_pkg::DEPTH : capacity;
            if (occupancy >= limit) begin
                victim = -1;
                oldest = 0;
                for (int i = 0; i < lruc_pkg::DEPTH; i++)
                    if (used[i] && (victim < 0 || rank[i] >= oldest)) begin
                        victim = i;
                        oldest = rank[i];
                    end
                if (victim >= 0) begin
                    used[victim] = 1'b0;
                    rank[victim] = 0;
                    if (occupancy > 0)
                        occupancy--;
                end
            end
            // Store the new entry in the first free slot as most recent
            for (int i = 0; i < lruc_pkg::DEPTH; i++)
                if (!used[i]) begin
                    for (int j = 0; j < lruc_pkg::DEPTH; j++)
                        if (used[j])
                            rank[j]++;
                    used[i] = 1'b1;
                    keys[i] = key;
                    vals[i] = payload;
                    rank[i] = 0;
                    occupancy++;
                    break;
                end
        endfunction

        function void check_result(logic hit, logic [31:0] data);
            reply_t want;
            if (due_replies.size() == 0) begin
                $error("result with no request outstanding: hit %0d data %h", hit, data);
                errors++;
                return;
            end
            want = due_replies.pop_front();
            if (hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, hit);
                errors++;
            end
            if (data !== want.data) begin
                $error("data: expected %h, got %h", want.data, data);
                errors++;
            end
        endfunction

        function int pending();
            return due_replies.size();
        endfunction
    endclass

    logic                                 aclk     = 1'b0;
    logic                                 aresetn  = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [95:0]                          s_tdata  = '0;  // key[63:0], payload[95:64]
    logic                                 s_tuser  = 1'b0; // cmd[0]
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [31:0]                          m_tdata;         // data[31:0]
    logic                                 m_tuser;         // hit[0]
    logic                                 psel     = 1'b0;
    logic                                 penable  = 1'b0;
    logic                                 pwrite   = 1'b0;
    logic [lruc_pkg::APB_ADDR_W-1:0]      paddr    = '0;
    logic [lruc_pkg::APB_DATA_W-1:0]      pwdata   = '0;
    logic [lruc_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;

    lru_shadow   model = new();
    bit          steady = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    logic [63:0] key_pool[POOL_SIZE];
    int          pool_used = POOL_SIZE;

    lru_cache_by_key DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // Mostly short gaps, now and then a long one; none in steady stretches
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Take results with random back-pressure and check each one
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                model.check_result(m_tuser, m_tdata);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                hold_left <= pick_gap();
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stop the run when neither channel moves an item for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(logic cmd, logic [63:0] key, logic [31:0] payload);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {payload, key};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        model.accept_request(cmd, key, payload);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [lruc_pkg::APB_ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAP_ADDR)
            model.set_capacity(value);
    endtask

    // Capacity write, at random with junk in the unused upper bits
    task automatic set_capacity(logic [4:0] cap);
        apb_write(CAP_ADDR, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, cap});
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return key_pool[$urandom_range(0, pool_used - 1)];
        if (r < 90)
            return {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return 64'd0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [31:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 10)
            return '1;
        return $urandom;
    endfunction

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            send_item($urandom_range(0, 1) ? lruc_pkg::CMD_INSERT : lruc_pkg::CMD_LOOKUP,
                      pick_key(), pick_payload());
    endtask

    initial begin
        logic [4:0] caps[10];
        int         eff;
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16, 5'd3, 5'd12, 5'd0};
        caps[9] = 5'($urandom_range(0, 31));
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty cache, key extremes, refresh without overwrite
        send_item(lruc_pkg::CMD_LOOKUP, KEY_MIN, 32'hDEAD_BEEF);
        send_item(lruc_pkg::CMD_INSERT, KEY_MIN, 32'd0);
        send_item(lruc_pkg::CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF);
        send_item(lruc_pkg::CMD_INSERT, 64'd0, 32'hA5A5_A5A5);
        send_item(lruc_pkg::CMD_INSERT, '1, 32'h5A5A_5A5A);
        send_item(lruc_pkg::CMD_LOOKUP, KEY_MIN, 32'hFFFF_FFFF);
        send_item(lruc_pkg::CMD_LOOKUP, KEY_MAX, 32'd0);
        send_item(lruc_pkg::CMD_INSERT, KEY_MAX, 32'h0000_1234);
        send_item(lruc_pkg::CMD_LOOKUP, KEY_MAX, 32'd0);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd1, 32'd0);
        // Capacity lowered below occupancy: one eviction per new key
        drain();
        set_capacity(5'd2);
        send_item(lruc_pkg::CMD_INSERT, 64'd1, 32'h1111_1111);
        send_item(lruc_pkg::CMD_INSERT, 64'd2, 32'h2222_2222);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd0, 32'd0);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd1, 32'd0);
        send_item(lruc_pkg::CMD_LOOKUP, KEY_MIN, 32'd0);
        // Capacity zero behaves as one
        drain();
        set_capacity(5'd0);
        send_item(lruc_pkg::CMD_INSERT, 64'd3, 32'h3333_3333);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd2, 32'd0);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd3, 32'd0);
        // Write to an unmapped register is ignored
        drain();
        apb_write(SPARE_ADDR, 32'd1);
        send_item(lruc_pkg::CMD_INSERT, 64'd4, 32'h4444_4444);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd3, 32'd0);
        send_item(lruc_pkg::CMD_LOOKUP, 64'd4, 32'd0);

        // Random phases over a range of capacities
        foreach (caps[p]) begin
            drain();
            steady = (p % 4 == 3);
            set_capacity(caps[p]);
            if ($urandom_range(0, 1))
                apb_write(SPARE_ADDR, $urandom);
            eff = (caps[p] == 0) ? 1 :
                  (caps[p] > lruc_pkg::DEPTH) ? lruc_pkg::DEPTH : caps[p];
            pool_used = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
            run_random(PHASE_ITEMS);
        end

        steady = 1'b0;
        drain();
        if (model.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/lruc_pkg.sv
sv/lruc_ctrl.sv
sv/lruc_datapath.sv
sv/lru_cache_by_key.sv
tb/lru_cache_by_key_tb.sv
